// ===== hw/rtl/dtpy_pkg.sv =====
// Shared constants, angle table and wrap helper for the direction-to-pitch/yaw block.
package dtpy_pkg;

  localparam int unsigned IN_WIDTH_DEF     = 32;
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  localparam int unsigned DW      = 64;
  localparam int unsigned ANG_W   = 28;
  localparam int unsigned OUT_W   = 25;
  localparam int unsigned GAIN_SH = 30;
  localparam int unsigned HI_W    = DW - GAIN_SH;

  localparam logic [GAIN_SH-1:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic signed [ANG_W-1:0] DEG_90  = 28'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG_180 = 28'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_270 = 28'sd17694720;
  localparam logic signed [ANG_W-1:0] DEG_360 = 28'sd23592960;

  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 28'sd2949120;
      5'd1:    r = 28'sd1740967;
      5'd2:    r = 28'sd919879;
      5'd3:    r = 28'sd466945;
      5'd4:    r = 28'sd234379;
      5'd5:    r = 28'sd117304;
      5'd6:    r = 28'sd58666;
      5'd7:    r = 28'sd29335;
      5'd8:    r = 28'sd14668;
      5'd9:    r = 28'sd7334;
      5'd10:   r = 28'sd3667;
      5'd11:   r = 28'sd1833;
      5'd12:   r = 28'sd917;
      5'd13:   r = 28'sd458;
      5'd14:   r = 28'sd229;
      5'd15:   r = 28'sd115;
      5'd16:   r = 28'sd57;
      5'd17:   r = 28'sd29;
      5'd18:   r = 28'sd14;
      5'd19:   r = 28'sd7;
      5'd20:   r = 28'sd4;
      5'd21:   r = 28'sd2;
      5'd22:   r = 28'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] wrap_deg(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    r = a;
    if (a < 0) begin
      r = a + DEG_360;
    end else if (a >= DEG_360) begin
      r = a - DEG_360;
    end
    return r[OUT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/direction_to_pitch_yaw.sv =====
// Top level: pipelined CORDIC conversion of a 3D direction into pitch and yaw degrees.
// Throughput: one transfer per cycle while in_stall_o is low; one CORDIC iteration per pipeline stage.
// An output skid register lets the pipe keep moving for one stalled result.
// Reset clears all valid bits and the skid flag; payload registers are not reset.
module direction_to_pitch_yaw #(
  parameter int unsigned IN_WIDTH     = dtpy_pkg::IN_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = dtpy_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [IN_WIDTH-1:0]        vec_x_i,
  input  logic [IN_WIDTH-1:0]        vec_y_i,
  input  logic [IN_WIDTH-1:0]        vec_z_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dtpy_pkg::OUT_W-1:0] pitch_deg_o,
  output logic [dtpy_pkg::OUT_W-1:0] yaw_deg_o,
  output logic                       vertical_case_o
);
  import dtpy_pkg::*;

  localparam int unsigned GUARD = 61 - IN_WIDTH;
  localparam int unsigned N     = CORDIC_STEPS;

  logic en;

  // input stage
  logic signed [DW-1:0] xe, ye, ze, xs, ys, nz;
  logic                 in_vert, in_zpos, in_zmin;

  always_comb begin
    xe      = {{(DW-IN_WIDTH){vec_x_i[IN_WIDTH-1]}}, vec_x_i};
    ye      = {{(DW-IN_WIDTH){vec_y_i[IN_WIDTH-1]}}, vec_y_i};
    ze      = {{(DW-IN_WIDTH){vec_z_i[IN_WIDTH-1]}}, vec_z_i};
    in_vert = (vec_x_i == '0) && (vec_y_i == '0);
    in_zpos = !vec_z_i[IN_WIDTH-1] && (vec_z_i != '0);
    in_zmin = (vec_z_i == {1'b1, {(IN_WIDTH-1){1'b0}}});
    xs      = xe <<< GUARD;
    ys      = ye <<< GUARD;
    if (vec_x_i[IN_WIDTH-1]) begin
      xs = -xs;
      ys = -ys;
    end
    if (in_zmin) begin
      nz = {{(DW-IN_WIDTH+1){1'b0}}, {(IN_WIDTH-1){1'b1}}};
    end else begin
      nz = -ze;
    end
  end

  // yaw CORDIC pipeline
  logic                    yv_q    [N+1];
  logic                    yvert_q [N+1];
  logic                    yzpos_q [N+1];
  logic                    ybase_q [N+1];
  logic signed [DW-1:0]    ynz_q   [N+1];
  logic signed [DW-1:0]    yx_q    [N+1];
  logic signed [DW-1:0]    yy_q    [N+1];
  logic signed [ANG_W-1:0] ya_q    [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yv_q[0] <= 1'b0;
    end else if (en) begin
      yv_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yvert_q[0] <= in_vert;
      yzpos_q[0] <= in_zpos;
      ybase_q[0] <= vec_x_i[IN_WIDTH-1];
      ynz_q[0]   <= nz <<< GUARD;
      yx_q[0]    <= xs;
      yy_q[0]    <= ys;
      ya_q[0]    <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_yaw
    logic signed [DW-1:0]    dx, dy, x_d, y_d;
    logic signed [ANG_W-1:0] a_d;

    always_comb begin
      dx = yy_q[k] >>> k;
      dy = yx_q[k] >>> k;
      if (!yy_q[k][DW-1]) begin
        x_d = yx_q[k] + dx;
        y_d = yy_q[k] - dy;
        a_d = ya_q[k] + atan_deg(5'(k));
      end else begin
        x_d = yx_q[k] - dx;
        y_d = yy_q[k] + dy;
        a_d = ya_q[k] - atan_deg(5'(k));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        yv_q[k+1] <= 1'b0;
      end else if (en) begin
        yv_q[k+1] <= yv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        yvert_q[k+1] <= yvert_q[k];
        yzpos_q[k+1] <= yzpos_q[k];
        ybase_q[k+1] <= ybase_q[k];
        ynz_q[k+1]   <= ynz_q[k];
        yx_q[k+1]    <= x_d;
        yy_q[k+1]    <= y_d;
        ya_q[k+1]    <= a_d;
      end
    end
  end

  // gain removal: split multiply, then sum
  logic [DW-1:0]           mag;
  logic [HI_W-1:0]         mag_hi;
  logic [GAIN_SH-1:0]      mag_lo;
  logic [DW-1:0]           prod_hi;
  logic [2*GAIN_SH-1:0]    prod_lo;
  logic signed [ANG_W-1:0] yaw_raw;

  always_comb begin
    mag     = yx_q[N][DW-1] ? '0 : yx_q[N];
    mag_hi  = mag[DW-1:GAIN_SH];
    mag_lo  = mag[GAIN_SH-1:0];
    prod_hi = DW'(mag_hi) * DW'(INV_GAIN_Q30);
    prod_lo = (2*GAIN_SH)'(mag_lo) * (2*GAIN_SH)'(INV_GAIN_Q30);
    yaw_raw = ya_q[N] + (ybase_q[N] ? DEG_180 : '0);
  end

  logic               g_v_q, g_vert_q, g_zpos_q;
  logic [DW-1:0]      g_nz_q, g_phi_q;
  logic [GAIN_SH-1:0] g_plo_q;
  logic [OUT_W-1:0]   g_yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (en) begin
      g_v_q <= yv_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_vert_q <= yvert_q[N];
      g_zpos_q <= yzpos_q[N];
      g_nz_q   <= ynz_q[N];
      g_phi_q  <= prod_hi;
      g_plo_q  <= prod_lo[2*GAIN_SH-1:GAIN_SH];
      g_yaw_q  <= wrap_deg(yaw_raw);
    end
  end

  // pitch CORDIC pipeline
  logic                    pv_q    [N+1];
  logic                    pvert_q [N+1];
  logic                    pzpos_q [N+1];
  logic [OUT_W-1:0]        pyaw_q  [N+1];
  logic signed [DW-1:0]    px_q    [N+1];
  logic signed [DW-1:0]    py_q    [N+1];
  logic signed [ANG_W-1:0] pa_q    [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else if (en) begin
      pv_q[0] <= g_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pvert_q[0] <= g_vert_q;
      pzpos_q[0] <= g_zpos_q;
      pyaw_q[0]  <= g_yaw_q;
      px_q[0]    <= g_phi_q + DW'(g_plo_q);
      py_q[0]    <= g_nz_q;
      pa_q[0]    <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_pitch
    logic signed [DW-1:0]    dx, dy, x_d, y_d;
    logic signed [ANG_W-1:0] a_d;

    always_comb begin
      dx = py_q[k] >>> k;
      dy = px_q[k] >>> k;
      if (!py_q[k][DW-1]) begin
        x_d = px_q[k] + dx;
        y_d = py_q[k] - dy;
        a_d = pa_q[k] + atan_deg(5'(k));
      end else begin
        x_d = px_q[k] - dx;
        y_d = py_q[k] + dy;
        a_d = pa_q[k] - atan_deg(5'(k));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[k+1] <= 1'b0;
      end else if (en) begin
        pv_q[k+1] <= pv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pvert_q[k+1] <= pvert_q[k];
        pzpos_q[k+1] <= pzpos_q[k];
        pyaw_q[k+1]  <= pyaw_q[k];
        px_q[k+1]    <= x_d;
        py_q[k+1]    <= y_d;
        pa_q[k+1]    <= a_d;
      end
    end
  end

  // final select
  logic             res_v_q, res_vert_q;
  logic [OUT_W-1:0] res_pitch_q, res_yaw_q;
  logic [OUT_W-1:0] pitch_d, yaw_d;

  always_comb begin
    if (pvert_q[N]) begin
      pitch_d = pzpos_q[N] ? DEG_270[OUT_W-1:0] : DEG_90[OUT_W-1:0];
      yaw_d   = '0;
    end else begin
      pitch_d = wrap_deg(pa_q[N]);
      yaw_d   = pyaw_q[N];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (en) begin
      res_v_q <= pv_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_vert_q  <= pvert_q[N];
      res_pitch_q <= pitch_d;
      res_yaw_q   <= yaw_d;
    end
  end

  // output register plus skid
  logic             out_valid_q, skid_v_q;
  logic             out_vert_q, skid_vert_q;
  logic [OUT_W-1:0] out_pitch_q, out_yaw_q, skid_pitch_q, skid_yaw_q;

  assign en = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (en) begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= res_v_q;
      end else if (res_v_q) begin
        skid_v_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b1;
      skid_v_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_valid_q || !out_stall_i) begin
        out_pitch_q <= res_pitch_q;
        out_yaw_q   <= res_yaw_q;
        out_vert_q  <= res_vert_q;
      end else begin
        skid_pitch_q <= res_pitch_q;
        skid_yaw_q   <= res_yaw_q;
        skid_vert_q  <= res_vert_q;
      end
    end else if (!out_stall_i) begin
      out_pitch_q <= skid_pitch_q;
      out_yaw_q   <= skid_yaw_q;
      out_vert_q  <= skid_vert_q;
    end
  end

  assign in_stall_o      = skid_v_q;
  assign out_valid_o     = out_valid_q;
  assign pitch_deg_o     = out_pitch_q;
  assign yaw_deg_o       = out_yaw_q;
  assign vertical_case_o = out_vert_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without a stalled output");

  a_vert_yaw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_vert_q) |-> (out_yaw_q == '0))
    else $error("vertical result with nonzero yaw");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_pitch_q < DEG_360[OUT_W-1:0]) && (out_yaw_q < DEG_360[OUT_W-1:0])))
    else $error("angle not wrapped below 360 degrees");

endmodule
